// ===== rtl/rau_pkg.sv =====
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int MAG_W = 2 * OPERAND_WIDTH;
	localparam int CNT_W = $clog2(MAG_W + 1);
	localparam int SHIFT_W = $clog2(MAG_W);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_DIVZERO  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_GCD,
		S_GDONE,
		S_DIV0,
		S_DIV1,
		S_CHECK
	} state_t;

	typedef struct packed {
		logic [1:0]                        op;
		logic signed [OPERAND_WIDTH-1:0]   a_num;
		logic signed [OPERAND_WIDTH-1:0]   a_den;
		logic signed [OPERAND_WIDTH-1:0]   b_num;
		logic signed [OPERAND_WIDTH-1:0]   b_den;
	} req_t;

	typedef struct packed {
		logic signed [OPERAND_WIDTH-1:0]   res_num;
		logic [OPERAND_WIDTH-2:0]          res_den;
		logic [1:0]                        status;
	} rsp_t;

endpackage

// ===== rtl/rau_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module rau_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rau_pkg::MAG_W-1:0]   dividend,
	input  logic [rau_pkg::MAG_W-1:0]   divisor,
	output logic                        done,
	output logic [rau_pkg::MAG_W-1:0]   quotient
);
	import rau_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] dsr_q;
	logic [MAG_W:0]   trial;

	// Shift in the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[MAG_W-1]};

	// Iteration counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Partial remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= MAG_W'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared multiplier and binary GCD.
//
// A request (op and two signed fractions on req) is taken at the clock edge where start is
// high and busy is low. One result appears on rsp for a single cycle, marked by done; the
// receiver must take it then, as there is no way to hold it off.
// Requests with a zero denominator or a zero divisor are answered in the next cycle, and a
// zero numerator result ends at the combine. Otherwise the work runs through three products
// on one shared 32x32 multiplier, a sign-magnitude combine, a binary GCD that does one shift
// or one 64-bit subtract per cycle, and two divisions by the GCD on a bit-serial divider.
// Busy stays high for all of this work.
// The result is reduced, with the sign on the numerator and a positive denominator; any
// error gives 0/1 with the error status. A reduced result outside the 32-bit range is
// reported as overflow.
// Reset returns the sequencer to idle and drops done; no result is pending afterwards.
module rational_arithmetic_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rau_pkg::req_t  req,
	output logic           done,
	output rau_pkg::rsp_t  rsp
);
	import rau_pkg::*;

	localparam int W = OPERAND_WIDTH;

	state_t state_q, state_d;

	logic [1:0]       op_q;
	logic [W-1:0]     an_q, ad_q, bn_q, bd_q;
	logic             sa_q, sb_q, neg_q;
	logic [MAG_W-1:0] p1_q, p2_q, p3_q;
	logic [MAG_W-1:0] x_q, y_q, g_q;
	logic [SHIFT_W-1:0] k_q;
	logic             done_q;
	rsp_t             rsp_q;

	logic             accept;
	logic [W-1:0]     an_m, ad_m, bn_m, bd_m;
	logic             bad_den, div_zero;
	logic [W-1:0]     mul_a, mul_b;
	logic [MAG_W-1:0] prod;
	logic             sbe;
	logic [MAG_W-1:0] comb_mag, comb_den;
	logic             comb_neg;
	logic             div_start, div_done;
	logic [MAG_W-1:0] div_dividend, div_quo;
	logic             ovf;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Operand magnitudes; the most negative value keeps its exact magnitude.
	assign an_m = req.a_num[W-1] ? W'(-req.a_num) : req.a_num;
	assign ad_m = req.a_den[W-1] ? W'(-req.a_den) : req.a_den;
	assign bn_m = req.b_num[W-1] ? W'(-req.b_num) : req.b_num;
	assign bd_m = req.b_den[W-1] ? W'(-req.b_den) : req.b_den;
	assign bad_den  = (req.a_den == '0) || (req.b_den == '0);
	assign div_zero = (op_t'(req.op) == OP_DIV) && (req.b_num == '0);

	// Shared multiplier operand selection.
	always_comb begin
		unique case (state_q)
			S_MUL0: begin
				mul_a = an_q;
				mul_b = (op_t'(op_q) == OP_MUL) ? bn_q : bd_q;
			end
			S_MUL1: begin
				mul_a = ad_q;
				mul_b = (op_t'(op_q) == OP_MUL) ? bd_q : bn_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
		endcase
	end
	assign prod = MAG_W'(mul_a) * MAG_W'(mul_b);

	// Combine the products into a sign-magnitude numerator and a denominator.
	always_comb begin
		sbe = sb_q ^ (op_t'(op_q) == OP_SUB);
		comb_den = p2_q;
		comb_mag = p1_q;
		comb_neg = sa_q ^ sb_q;
		if ((op_t'(op_q) == OP_ADD) || (op_t'(op_q) == OP_SUB)) begin
			comb_den = p3_q;
			if (sa_q == sbe) begin
				comb_neg = sa_q;
				comb_mag = p1_q + p2_q;
			end else if (p1_q >= p2_q) begin
				comb_neg = sa_q;
				comb_mag = p1_q - p2_q;
			end else begin
				comb_neg = sbe;
				comb_mag = p2_q - p1_q;
			end
		end
	end

	// Shared divider reduces numerator, then denominator, by the GCD.
	assign div_start    = (state_q == S_GDONE) || ((state_q == S_DIV0) && div_done);
	assign div_dividend = (state_q == S_GDONE) ? p1_q : p2_q;

	rau_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Range check of the reduced result.
	assign ovf = (p2_q[MAG_W-1:W-1] != '0) ||
		(neg_q ? (p1_q > (MAG_W'(1) << (W-1))) : (p1_q[MAG_W-1:W-1] != '0));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept && !bad_den && !div_zero) state_d = S_MUL0;
			S_MUL0:  state_d = S_MUL1;
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_COMB;
			S_COMB:  state_d = (comb_mag == '0) ? S_IDLE : S_GCD;
			S_GCD:   if (x_q == y_q) state_d = S_GDONE;
			S_GDONE: state_d = S_DIV0;
			S_DIV0:  if (div_done) state_d = S_DIV1;
			S_DIV1:  if (div_done) state_d = S_CHECK;
			S_CHECK: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && (bad_den || div_zero)) ||
				((state_q == S_COMB) && (comb_mag == '0)) || (state_q == S_CHECK);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req.op;
			an_q <= an_m;
			ad_q <= ad_m;
			bn_q <= bn_m;
			bd_q <= bd_m;
			sa_q <= req.a_num[W-1] ^ req.a_den[W-1];
			sb_q <= req.b_num[W-1] ^ req.b_den[W-1];
			rsp_q.res_num <= '0;
			rsp_q.res_den <= (W-1)'(1);
			rsp_q.status  <= bad_den ? ST_INVALID : ST_DIVZERO;
		end
		unique case (state_q)
			S_MUL0: p1_q <= prod;
			S_MUL1: p2_q <= prod;
			S_MUL2: p3_q <= prod;
			S_COMB: begin
				p1_q  <= comb_mag;
				p2_q  <= comb_den;
				x_q   <= comb_mag;
				y_q   <= comb_den;
				neg_q <= comb_neg;
				k_q   <= '0;
				rsp_q.res_num <= '0;
				rsp_q.res_den <= (W-1)'(1);
				rsp_q.status  <= ST_OK;
			end
			// Binary GCD: one shift or one subtraction per cycle.
			S_GCD: begin
				if (x_q == y_q) begin
					g_q <= x_q << k_q;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + SHIFT_W'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			S_DIV0: if (div_done) p1_q <= div_quo;
			S_DIV1: if (div_done) p2_q <= div_quo;
			S_CHECK: begin
				if (ovf) begin
					rsp_q.res_num <= '0;
					rsp_q.res_den <= (W-1)'(1);
					rsp_q.status  <= ST_OVERFLOW;
				end else begin
					rsp_q.res_num <= neg_q ? W'(-p1_q[W-1:0]) : p1_q[W-1:0];
					rsp_q.res_den <= p2_q[W-2:0];
					rsp_q.status  <= ST_OK;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// A result is only delivered once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobed while busy");

	// A zero denominator is answered on the next cycle as invalid.
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((req.a_den == '0) || (req.b_den == '0)))
		|=> (done && (rsp.status == ST_INVALID)))
		else $error("invalid argument not reported");

	// Every error result reads 0/1.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status != ST_OK)) |-> ((rsp.res_num == '0) && (rsp.res_den == 31'd1)))
		else $error("error result not 0/1");

endmodule

// ===== test/rational_arithmetic_unit_tb.sv =====
// Self-checking testbench for the rational arithmetic unit: random and directed fraction requests.
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;
	localparam int NUM_RANDOM = 800;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  done;
	rsp_t  rsp;

	int    mismatches;
	int    idle_cycles;
	int    n_sent;
	int    n_checked;
	int    status_seen[4];

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Holds the reduced fractions still owed by the block, oldest first.
	class fraction_scoreboard;
		rsp_t  owed[$];

		// Compute the exact reduced result of one request and queue it.
		function void note_request(req_t r);
			rsp_t                  e;
			logic [63:0]           an, ad, bn, bd, t1, t2, rmag, rden, x, y, t;
			logic                  sa, sb, rneg;
			an = r.a_num[31] ? 64'(-64'(signed'(r.a_num))) : 64'(r.a_num);
			ad = r.a_den[31] ? 64'(-64'(signed'(r.a_den))) : 64'(r.a_den);
			bn = r.b_num[31] ? 64'(-64'(signed'(r.b_num))) : 64'(r.b_num);
			bd = r.b_den[31] ? 64'(-64'(signed'(r.b_den))) : 64'(r.b_den);
			e.res_num = '0;
			e.res_den = 31'd1;
			e.status = ST_OK;
			if (ad == 0 || bd == 0) begin
				e.status = ST_INVALID;
			end else if (op_t'(r.op) == OP_DIV && bn == 0) begin
				e.status = ST_DIVZERO;
			end else begin
				sa = r.a_num[31] ^ r.a_den[31];
				sb = r.b_num[31] ^ r.b_den[31];
				case (op_t'(r.op))
					OP_MUL: begin
						rneg = sa ^ sb;
						rmag = an * bn;
						rden = ad * bd;
					end
					OP_DIV: begin
						rneg = sa ^ sb;
						rmag = an * bd;
						rden = ad * bn;
					end
					default: begin
						t1 = an * bd;
						t2 = ad * bn;
						if (op_t'(r.op) == OP_SUB)
							sb = !sb;
						rden = ad * bd;
						if (sa == sb) begin
							rneg = sa;
							rmag = t1 + t2;
						end else if (t1 >= t2) begin
							rneg = sa;
							rmag = t1 - t2;
						end else begin
							rneg = sb;
							rmag = t2 - t1;
						end
					end
				endcase
				if (rmag != 0) begin
					x = rmag;
					y = rden;
					while (y != 0) begin
						t = x % y;
						x = y;
						y = t;
					end
					rmag = rmag / x;
					rden = rden / x;
					if (rden > 64'h7FFF_FFFF ||
							rmag > (rneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
						e.status = ST_OVERFLOW;
					end else begin
						e.res_num = rneg ? 32'(-rmag) : 32'(rmag);
						e.res_den = 31'(rden);
					end
				end
			end
			owed.push_back(e);
		endfunction

		// Compare one result with the oldest owed fraction.
		task check_result(rsp_t got);
			rsp_t  e;
			if (owed.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			e = owed.pop_front();
			status_seen[e.status]++;
			n_checked++;
			if (got.res_num !== e.res_num)
				report_mismatch($sformatf("res_num got %0d want %0d",
					$signed(got.res_num), $signed(e.res_num)));
			if (got.res_den !== e.res_den)
				report_mismatch($sformatf("res_den got %0d want %0d", got.res_den, e.res_den));
			if (got.status !== e.status)
				report_mismatch($sformatf("status got %0d want %0d", got.status, e.status));
		endtask
	endclass

	fraction_scoreboard  board;

	rational_arithmetic_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// Free-running clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Check every result on the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(rsp);
	end

	// Watchdog: count cycles in which nothing is accepted or delivered.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Present one request and hold it until the block takes it; start stays high after.
	task automatic send_request(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		req_t  r;
		r.op = op;
		r.a_num = an;
		r.a_den = ad;
		r.b_num = bn;
		r.b_den = bd;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(r);
		n_sent++;
	endtask

	// Random gap between bursts of requests; start drops only when there is a gap.
	task automatic idle_gap();
		int  n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : 0;
		if (n > 0)
			start <= 1'b0;
		repeat (n)
			@(posedge clk);
	endtask

	// Operand with a bias toward edges and small values, so reductions stay interesting.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 40)) - 20);
			3: return 32'($signed($urandom_range(0, 2000)) - 1000);
			4: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
			5: return 32'($urandom_range(1, 65535)) << $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Nonzero denominators mostly, sometimes zero.
	function automatic logic [31:0] pick_denominator();
		logic [31:0]  v;
		if ($urandom_range(0, 40) == 0)
			return 32'd0;
		v = pick_operand();
		return v == 0 ? 32'd7 : v;
	endfunction

	initial begin
		int  burst;
		board = new();
		mismatches = 0;
		idle_cycles = 0;
		n_sent = 0;
		n_checked = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: every operation, each error, zero results and range edges.
		send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		send_request(OP_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
		send_request(OP_DIV, 32'd5, 32'd6, -32'sd10, 32'd3);
		send_request(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		send_request(OP_DIV, 32'd1, 32'd1, 32'd0, 32'd0);
		send_request(OP_DIV, 32'd1, 32'd1, 32'd0, 32'd5);
		send_request(OP_SUB, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
		send_request(OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd1);
		send_request(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
		send_request(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
		send_request(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
		send_request(OP_ADD, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
		send_request(OP_MUL, 32'd0, 32'h8000_0000, 32'd5, 32'd7);
		send_request(OP_DIV, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
		send_request(OP_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
		send_request(OP_SUB, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_MUL, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);

		// Random requests in bursts with gaps between them.
		while (n_sent < NUM_RANDOM + 18) begin
			burst = $urandom_range(1, 12);
			repeat (burst)
				send_request(2'($urandom_range(0, 3)), pick_operand(), pick_denominator(),
					pick_operand(), pick_denominator());
			idle_gap();
		end
		start <= 1'b0;

		// Drain the last result, then a few spare cycles.
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		$display("%0d requests sent, %0d results checked", n_sent, n_checked);
		$display("status counts: ok %0d, invalid %0d, divide by zero %0d, overflow %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && board.owed.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
